[sv/tdbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdbd_pkg: shared types and constants of the touch detector
// Transaction payload structs, register indexes, ring sizing and reset values.
// ----------------------------------------------------------------------------
package tdbd_pkg;

  // Ring sizing
  localparam int RING_DEPTH = 32;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int SAMPLE_W   = 32;
  localparam int AVG_W      = SAMPLE_W - SLOT_W;

  // Configuration register widths and reset values
  localparam int MARGIN_W   = 4;
  localparam int DEBOUNCE_W = 8;
  localparam int THR_W      = SAMPLE_W + MARGIN_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [MARGIN_W-1:0]   MARGIN_RST   = MARGIN_W'(2);
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(100);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_MARGIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] charge_time;
    logic                rebaseline;
  } tdbd_in_t;

  typedef struct packed {
    logic             touched;
    logic [AVG_W-1:0] average;
  } tdbd_out_t;

endpackage

[sv/touch_detector_baseline_debounce_unit.sv]
`timescale 1ns / 1ps
// Takes one transaction per clock cycle while in_ready is high: a charge-time
// sample or a rebaseline request goes in, and one result with the debounced
// touch flag and the ring average is registered; one item per cycle is
// sustained while the receiver keeps up. The single ring read-modify-write
// with its running sum feeds the threshold compare and debounce countdown; a
// two-entry output buffer keeps the input open while one result waits.
// ----------------------------------------------------------------------------
// touch_detector_baseline_debounce_unit
// Moving-average baseline capture with a debounced touch threshold.
// ----------------------------------------------------------------------------
module touch_detector_baseline_debounce_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  tdbd_pkg::tdbd_in_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output tdbd_pkg::tdbd_out_t                     out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tdbd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tdbd_pkg::CFG_DATA_W-1:0]         cfg_data
);

  // Configuration registers
  logic [tdbd_pkg::MARGIN_W-1:0]   margin_r;
  logic [tdbd_pkg::DEBOUNCE_W-1:0] debounce_r;

  // Detector state
  logic [tdbd_pkg::SAMPLE_W-1:0]   ring_mem [tdbd_pkg::RING_DEPTH];
  logic [tdbd_pkg::SAMPLE_W-1:0]   old_r;
  logic [tdbd_pkg::RING_DEPTH-1:0] ring_vld_r, ring_vld_nxt;
  logic [tdbd_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [tdbd_pkg::SAMPLE_W-1:0]   sum_r, sum_nxt;
  logic                            base_ready_r, base_ready_nxt;
  logic [tdbd_pkg::SAMPLE_W-1:0]   baseline_r, baseline_nxt;
  logic                            flag_r, flag_nxt;
  logic [tdbd_pkg::DEBOUNCE_W-1:0] hold_r, hold_nxt;

  // Output buffer
  logic                            out_vld_r, out_vld_nxt;
  logic                            skid_vld_r, skid_vld_nxt;
  tdbd_pkg::tdbd_out_t             out_r, out_nxt;
  tdbd_pkg::tdbd_out_t             skid_r, skid_nxt;

  // Datapath signals
  logic                            acc;
  logic                            pop;
  logic [tdbd_pkg::SAMPLE_W-1:0]   old_sample;
  logic [tdbd_pkg::SAMPLE_W-1:0]   new_sum;
  logic [tdbd_pkg::AVG_W-1:0]      avg;
  logic                            capture;
  logic [tdbd_pkg::THR_W-1:0]      threshold;
  logic                            qual;
  logic [tdbd_pkg::DEBOUNCE_W-1:0] hold_base;
  logic [tdbd_pkg::DEBOUNCE_W-1:0] hold_dec;
  tdbd_pkg::tdbd_out_t             result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_vld_r;
  assign acc       = in_valid && in_ready;
  assign pop       = out_vld_r && out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r   <= tdbd_pkg::MARGIN_RST;
      debounce_r <= tdbd_pkg::DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tdbd_pkg::REG_TOUCH_MARGIN: begin
          margin_r <= cfg_data[tdbd_pkg::MARGIN_W-1:0];
        end
        tdbd_pkg::REG_DEBOUNCE_COUNT: begin
          debounce_r <= cfg_data[tdbd_pkg::DEBOUNCE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Use the prefetched oldest sample; a slot never written since clear reads as zero
  assign old_sample = ring_vld_r[slot_r] ? old_r : '0;
  assign new_sum    = sum_r - old_sample + in_data.charge_time;
  assign avg        = tdbd_pkg::AVG_W'(new_sum / tdbd_pkg::RING_DEPTH);
  assign capture    = (slot_r == tdbd_pkg::SLOT_W'(tdbd_pkg::RING_DEPTH - 1)) && !base_ready_r;
  assign threshold  = tdbd_pkg::THR_W'(baseline_r) * tdbd_pkg::THR_W'(margin_r);

  // Qualify the average; on the capture step the threshold is avg times margin
  always_comb begin
    if (capture) begin
      qual = (margin_r == '0) && (avg != '0);
    end else if (flag_r) begin
      qual = tdbd_pkg::THR_W'(avg) < threshold;
    end else begin
      qual = tdbd_pkg::THR_W'(avg) > threshold;
    end
  end

  assign hold_base = capture ? debounce_r : hold_r;
  assign hold_dec  = hold_base - tdbd_pkg::DEBOUNCE_W'(1);

  // Advance the detector state for one accepted transaction
  always_comb begin
    ring_vld_nxt   = ring_vld_r;
    slot_nxt       = slot_r;
    sum_nxt        = sum_r;
    base_ready_nxt = base_ready_r;
    baseline_nxt   = baseline_r;
    flag_nxt       = flag_r;
    hold_nxt       = hold_r;
    result.touched = 1'b0;
    result.average = '0;
    if (acc) begin
      if (in_data.rebaseline) begin
        ring_vld_nxt   = '0;
        slot_nxt       = '0;
        sum_nxt        = '0;
        base_ready_nxt = 1'b0;
        baseline_nxt   = '0;
        flag_nxt       = 1'b0;
        hold_nxt       = debounce_r;
      end else begin
        ring_vld_nxt[slot_r] = 1'b1;
        sum_nxt              = new_sum;
        if (slot_r == tdbd_pkg::SLOT_W'(tdbd_pkg::RING_DEPTH - 1)) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_r + tdbd_pkg::SLOT_W'(1);
        end
        if (capture) begin
          base_ready_nxt = 1'b1;
          baseline_nxt   = tdbd_pkg::SAMPLE_W'(avg);
        end
        if (capture || base_ready_r) begin
          if (qual) begin
            if (hold_dec == '0) begin
              flag_nxt = !flag_r;
              hold_nxt = debounce_r;
            end else begin
              hold_nxt = hold_dec;
            end
          end else begin
            hold_nxt = debounce_r;
          end
        end
        result.touched = flag_nxt;
        result.average = avg;
      end
    end
  end

  // Hold or move results through the output register and skid stage
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (pop || !out_vld_r) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (acc) begin
        out_vld_nxt = 1'b1;
        out_nxt     = result;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (acc) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = result;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r   <= '0;
      slot_r       <= '0;
      sum_r        <= '0;
      base_ready_r <= 1'b0;
      baseline_r   <= '0;
      flag_r       <= 1'b0;
      hold_r       <= tdbd_pkg::DEBOUNCE_RST;
      out_vld_r    <= 1'b0;
      skid_vld_r   <= 1'b0;
    end else begin
      ring_vld_r   <= ring_vld_nxt;
      slot_r       <= slot_nxt;
      sum_r        <= sum_nxt;
      base_ready_r <= base_ready_nxt;
      baseline_r   <= baseline_nxt;
      flag_r       <= flag_nxt;
      hold_r       <= hold_nxt;
      out_vld_r    <= out_vld_nxt;
      skid_vld_r   <= skid_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Write the sample ring
  always_ff @(posedge clk) begin
    if (acc && !in_data.rebaseline) begin
      ring_mem[slot_r] <= in_data.charge_time;
    end
  end

  // Prefetch the slot that the next transaction overwrites
  always_ff @(posedge clk) begin
    old_r <= ring_mem[slot_nxt];
  end

  // Skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a result with the output register empty");

  // Rebaseline clears the running sum and baseline capture
  a_rebase_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.rebaseline |=> !base_ready_r && sum_r == '0 && !flag_r)
    else $error("rebaseline left detector state behind");

  // Touch flag moves only on an accepted transaction
  a_flag_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(flag_r))
    else $error("touch flag changed without a transaction");

  // No touch before a baseline is captured
  a_no_touch_early: assert property (@(posedge clk) disable iff (!rst_n)
    !base_ready_r |-> !flag_r)
    else $error("touch flag set before baseline capture");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: touch detector baseline and debounce regression
// Drives sample and rebaseline transactions into the detector and checks each
// result against a cycle-free predictor of the ring average, baseline capture,
// threshold compare and debounce countdown. Registers are rewritten between
// scenes while the block is idle. Both channels stall at random, and the
// receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import tdbd_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 10;
  localparam int STALL_LIMIT   = 1000;
  localparam int HOLD_CYCLES   = 40;
  localparam int RANDOM_TARGET = 940;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tdbd_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tdbd_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: registers and detector state
  logic [MARGIN_W-1:0]   margin_q;
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [SAMPLE_W-1:0]   ring_q [RING_DEPTH];
  logic [SLOT_W-1:0]     slot_q;
  logic [SAMPLE_W-1:0]   sum_q;
  logic                  baseline_ok;
  logic [SAMPLE_W-1:0]   baseline_q;
  logic                  touched_q;
  logic [DEBOUNCE_W-1:0] countdown_q;

  tdbd_out_t touch_readings_due[$];
  int        samples_sent = 0;
  int        mismatch_count = 0;
  int        stuck_cycles = 0;

  // Stimulus and receiver control
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int stall_left = 0;

  touch_detector_baseline_debounce_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clear the detector state; registers keep their values
  function automatic void clear_detector();
    for (int i = 0; i < RING_DEPTH; i++) ring_q[i] = '0;
    slot_q      = '0;
    sum_q       = '0;
    baseline_ok = 1'b0;
    baseline_q  = '0;
    touched_q   = 1'b0;
    countdown_q = debounce_q;
  endfunction

  // Advance the detector by one transaction and return its reading
  function automatic tdbd_out_t predict_touch(input tdbd_in_t item);
    logic [SAMPLE_W-1:0] avg;
    logic [THR_W-1:0]    thr;
    logic                hit;
    tdbd_out_t           res;
    if (item.rebaseline) begin
      clear_detector();
      res = '0;
      return res;
    end
    sum_q = sum_q - ring_q[slot_q] + item.charge_time;
    ring_q[slot_q] = item.charge_time;
    avg = sum_q / SAMPLE_W'(RING_DEPTH);
    // Capture the baseline when the ring first fills
    if (slot_q == SLOT_W'(RING_DEPTH - 1) && !baseline_ok) begin
      baseline_ok = 1'b1;
      baseline_q  = avg;
      countdown_q = debounce_q;
    end
    slot_q = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    // Debounce against the full-width threshold
    if (baseline_ok) begin
      thr = THR_W'(baseline_q) * THR_W'(margin_q);
      hit = touched_q ? (THR_W'(avg) < thr) : (THR_W'(avg) > thr);
      if (hit) begin
        countdown_q = countdown_q - 1'b1;
        if (countdown_q == '0) begin
          touched_q   = !touched_q;
          countdown_q = debounce_q;
        end
      end else begin
        countdown_q = debounce_q;
      end
    end
    res.touched = touched_q;
    res.average = avg[AVG_W-1:0];
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] near(input logic [SAMPLE_W-1:0] level);
    return level - level / 16 + $urandom_range(0, level / 8);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("mismatch %s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, want);
  endtask

  // Offer one transaction and hold it until accepted
  task automatic push_sample(input tdbd_in_t item);
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    touch_readings_due.push_back(predict_touch(item));
    samples_sent++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] level, input int noise_pct);
    tdbd_in_t item;
    item.charge_time = level;
    item.rebaseline  = 1'b0;
    if ($urandom_range(0, 99) < noise_pct) begin
      item.charge_time = $urandom;
      item.rebaseline  = ($urandom_range(0, 9) == 0);
    end
    push_sample(item);
  endtask

  task automatic send_rebaseline();
    tdbd_in_t item;
    item.charge_time = $urandom;
    item.rebaseline  = 1'b1;
    push_sample(item);
  endtask

  // Drop valid and wait until every reading has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (touch_readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic configure(input logic [MARGIN_W-1:0] margin,
                           input logic [DEBOUNCE_W-1:0] debounce);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_TOUCH_MARGIN;
    cfg_data  <= {4'($urandom), margin};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    margin_q = margin;
    cfg_index <= REG_DEBOUNCE_COUNT;
    cfg_data  <= debounce;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    debounce_q = debounce;
    cfg_valid <= 1'b0;
  endtask

  // Fill the ring at a resting level, then press and release
  task automatic run_press_scene(input logic [MARGIN_W-1:0] margin,
                                 input logic [DEBOUNCE_W-1:0] debounce,
                                 input int presses, input int noise_pct,
                                 input bit sure_press, input bit fresh);
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] high;
    int                  need;
    int                  len;
    configure(margin, debounce);
    base = $urandom_range(16, 1 << 20);
    high = base * (2 * margin + 2) + 16;
    need = RING_DEPTH + ((debounce == '0) ? 256 : int'(debounce));
    if (fresh) send_rebaseline();
    repeat (RING_DEPTH) send_sample(near(base), noise_pct);
    repeat (presses) begin
      len = sure_press ? need + 4 : $urandom_range(need / 2, need + 8);
      repeat (len) send_sample(near(high), noise_pct);
      len = sure_press ? RING_DEPTH : $urandom_range(need / 2, need + 8);
      repeat (len) send_sample(near(base / 2), noise_pct);
    end
  endtask

  // Field extremes and rebaseline at reset register values
  task automatic test_field_extremes();
    logic [SAMPLE_W-1:0] levels [12] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                         32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
                                         32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678};
    tdbd_in_t item;
    foreach (levels[i]) send_sample(levels[i], 0);
    item.rebaseline  = 1'b1;
    item.charge_time = 32'hFFFF_FFFF;
    push_sample(item);
    send_sample(32'hFFFF_FFFF, 0);
    item.charge_time = 32'h0000_0000;
    push_sample(item);
    send_sample(32'h0000_0000, 0);
  endtask

  // Average exactly at the threshold never qualifies, in either state
  task automatic test_equal_threshold();
    logic [SAMPLE_W-1:0] level;
    configure(4'd1, 8'd2);
    level = $urandom_range(1000, 1 << 20);
    send_rebaseline();
    repeat (RING_DEPTH + 8) send_sample(level, 0);
    repeat (40) send_sample(level * 3, 0);
    repeat (RING_DEPTH + 5) send_sample(level, 0);
    repeat (40) send_sample(level / 2, 0);
  endtask

  // Zero margin: the capture step itself already qualifies
  task automatic test_margin_zero();
    configure(4'd0, 8'd1);
    send_rebaseline();
    repeat (RING_DEPTH) send_sample($urandom_range(1, 1 << 16), 0);
    repeat (10) send_sample('0, 0);
  endtask

  // Debounce count of zero wraps to a 256-long countdown; also use the top count
  task automatic test_debounce_extremes();
    run_press_scene(4'd2, 8'd0, 1, 0, 1'b1, 1'b1);
    run_press_scene(4'd15, 8'd255, 0, 0, 1'b0, 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    configure(4'd3, 8'd4);
    tx_idling = 1'b0;
    hold_request = HOLD_CYCLES;
    send_rebaseline();
    repeat (24) send_sample(near(32'd50_000), 0);
    tx_idling = 1'b1;
  endtask

  // Sender pauses until every reading has drained
  task automatic test_drain_pause();
    repeat (10) send_sample(near(32'd50_000), 5);
    wait_idle();
    repeat (10) send_sample(near(32'd80_000), 5);
  endtask

  task automatic test_random_scenes();
    logic [MARGIN_W-1:0]   margin;
    logic [DEBOUNCE_W-1:0] debounce;
    int                    presses;
    int                    pick;
    while (samples_sent < RANDOM_TARGET) begin
      pick = $urandom_range(0, 9);
      margin = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom_range(1, 14));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        debounce = 8'($urandom_range(1, 10));
        presses  = $urandom_range(1, 3);
      end else if (pick < 9) begin
        debounce = 8'($urandom_range(11, 40));
        presses  = 1;
      end else begin
        debounce = 8'($urandom);
        presses  = 0;
      end
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      run_press_scene(margin, debounce, presses, $urandom_range(0, 12), 1'b0,
                      $urandom_range(0, 3) != 0);
    end
  endtask

  // Final stretch at full rate with no idling on either side
  task automatic test_final_stream();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    run_press_scene(4'($urandom_range(1, 4)), 8'($urandom_range(1, 6)), 1, 0, 1'b1,
                    1'b1);
  endtask

  // Receiver: long hold on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted reading with the oldest prediction
  always @(posedge clk) begin
    tdbd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (touch_readings_due.size() == 0) begin
        report_mismatch("unexpected reading", out_data, 0);
      end else begin
        want = touch_readings_due.pop_front();
        if (out_data.touched !== want.touched)
          report_mismatch("touched", out_data.touched, want.touched);
        if (out_data.average !== want.average)
          report_mismatch("average", out_data.average, want.average);
      end
    end
  end

  // Count cycles in which no transaction moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    margin_q   = MARGIN_RST;
    debounce_q = DEBOUNCE_RST;
    clear_detector();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_equal_threshold();
    test_margin_zero();
    test_debounce_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_scenes();
    test_final_stream();

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && touch_readings_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
